>>> hdl/tppm_pkg.sv
// ----------------------------------------------------------------------------
// Throughput peak percent meter package
// Shared widths, window depth and the operand/result types of the shared
// compare-subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tppm_pkg;

  localparam int unsigned WINDOW_DEPTH = 15;
  localparam int unsigned SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CNT_W        = 64;
  localparam int unsigned PCT_W        = 7;
  localparam int unsigned QBIT_W       = 3;
  localparam int unsigned NUM_W        = CNT_W + PCT_W;

  localparam logic [PCT_W-1:0]  PCT_MAX  = PCT_W'(100);
  localparam logic [QBIT_W-1:0] QBIT_TOP = QBIT_W'(PCT_W - 1);
  localparam logic [SLOT_W-1:0] SLOT_END = SLOT_W'(WINDOW_DEPTH - 1);

  // operands of the shared unit: a is one bit wider to carry a shifted remainder
  typedef struct packed {
    logic [CNT_W:0]   a;
    logic [CNT_W-1:0] b;
  } cu_req_t;

  typedef struct packed {
    logic           ge;
    logic [CNT_W:0] diff;
  } cu_rsp_t;

endpackage

`default_nettype wire

>>> hdl/tppm_cmpsub.sv
// ----------------------------------------------------------------------------
// Shared compare-subtract unit
// Returns a - b and whether a >= b; serves delta, peak scan and division.
// ----------------------------------------------------------------------------
`default_nettype none

module tppm_cmpsub (
  input  wire tppm_pkg::cu_req_t req,
  output tppm_pkg::cu_rsp_t      rsp
);

  logic [tppm_pkg::CNT_W+1:0] full;

  assign full     = {1'b0, req.a} - {2'b00, req.b};
  assign rsp.ge   = ~full[tppm_pkg::CNT_W+1];
  assign rsp.diff = full[tppm_pkg::CNT_W:0];

endmodule

`default_nettype wire

>>> hdl/throughput_peak_percent_meter_top.sv
// ----------------------------------------------------------------------------
// Throughput peak percent meter
// Per-interval byte deltas, windowed peaks and percent of peak for rx and tx.
// ----------------------------------------------------------------------------
// Sequence: after the accept, the delta step (rx, then tx), the peak scan over
//   every window slot, the divide (rx, then tx) and the output register.
// A new item is taken only in idle, after the last one is through; every step
//   goes through the single shared compare-subtract unit.
//   A stalled result holds the next item in its last step until it leaves.
// Reset: synchronous, active low; clears counters, window valid bits, slot
//   and handshake state. No clearing pass is needed.
`default_nettype none

module throughput_peak_percent_meter_top (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  [tppm_pkg::CNT_W-1:0]        in_rx_total,
  input  wire  [tppm_pkg::CNT_W-1:0]        in_tx_total,
  input  wire                               in_clear_history,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic                              out_primed,
  output logic [tppm_pkg::CNT_W-1:0]        out_rx_delta,
  output logic [tppm_pkg::CNT_W-1:0]        out_tx_delta,
  output logic [tppm_pkg::CNT_W-1:0]        out_rx_peak,
  output logic [tppm_pkg::CNT_W-1:0]        out_tx_peak,
  output logic [tppm_pkg::PCT_W-1:0]        out_rx_percent,
  output logic [tppm_pkg::PCT_W-1:0]        out_tx_percent
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DELTA,
    ST_SCAN,
    ST_DIVINIT,
    ST_DIV,
    ST_FINISH
  } state_t;

  state_t state_r;

  logic [tppm_pkg::CNT_W-1:0]  rx_in_r, tx_in_r;
  logic [tppm_pkg::CNT_W-1:0]  prev_rx_r, prev_tx_r;
  logic [tppm_pkg::CNT_W-1:0]  rd_r, td_r;
  logic [tppm_pkg::CNT_W-1:0]  rx_pk_r, tx_pk_r;
  logic [tppm_pkg::CNT_W-1:0]  rem_r;
  logic [tppm_pkg::PCT_W-1:0]  num_lo_r;
  logic [tppm_pkg::PCT_W-1:0]  q_r;
  logic [tppm_pkg::PCT_W-1:0]  rx_pct_r, tx_pct_r;
  logic [tppm_pkg::QBIT_W-1:0] bit_r;
  logic [tppm_pkg::SLOT_W-1:0] slot_r, idx_r;
  logic                        dir_r, primed_r;
  logic [tppm_pkg::WINDOW_DEPTH-1:0] vld_r;

  logic [tppm_pkg::CNT_W-1:0] rx_win_r [tppm_pkg::WINDOW_DEPTH];
  logic [tppm_pkg::CNT_W-1:0] tx_win_r [tppm_pkg::WINDOW_DEPTH];

  tppm_pkg::cu_req_t cu_req;
  tppm_pkg::cu_rsp_t cu_rsp;

  logic                       in_acc;
  logic                       win_we;
  logic [tppm_pkg::CNT_W-1:0] td_nxt;
  logic [tppm_pkg::CNT_W-1:0] rx_cand, tx_cand, cand, pk_sel, d_sel;
  logic [tppm_pkg::NUM_W-1:0] d_ext, num_full;
  logic [tppm_pkg::PCT_W-1:0] q_nxt, pct_nxt;

  tppm_cmpsub u_cmpsub (
    .req (cu_req),
    .rsp (cu_rsp)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid & ~in_stall;

  // invalid entries read as zero
  assign rx_cand = vld_r[idx_r] ? rx_win_r[idx_r] : '0;
  assign tx_cand = vld_r[idx_r] ? tx_win_r[idx_r] : '0;
  assign cand    = dir_r ? tx_cand : rx_cand;
  assign pk_sel  = dir_r ? tx_pk_r : rx_pk_r;
  assign d_sel   = dir_r ? td_r : rd_r;

  // delta*100 as shift-add: 64 + 32 + 4
  assign d_ext    = {{tppm_pkg::PCT_W{1'b0}}, d_sel};
  assign num_full = (d_ext << 6) + (d_ext << 5) + (d_ext << 2);

  assign td_nxt  = primed_r ? cu_rsp.diff[tppm_pkg::CNT_W-1:0] : '0;
  assign win_we  = (state_r == ST_DELTA) && dir_r;
  assign q_nxt   = {q_r[tppm_pkg::PCT_W-2:0], cu_rsp.ge};
  assign pct_nxt = (pk_sel == '0) ? '0 :
                   (q_nxt > tppm_pkg::PCT_MAX) ? tppm_pkg::PCT_MAX : q_nxt;

  always_comb begin
    cu_req = '0;
    unique case (state_r)
      ST_DELTA: begin
        cu_req.a = {1'b0, (dir_r ? tx_in_r : rx_in_r)};
        cu_req.b = dir_r ? prev_tx_r : prev_rx_r;
      end
      ST_SCAN: begin
        cu_req.a = {1'b0, pk_sel};
        cu_req.b = cand;
      end
      ST_DIV: begin
        cu_req.a = {rem_r, num_lo_r[bit_r]};
        cu_req.b = pk_sel;
      end
      default: cu_req = '0;
    endcase
  end

  // window storage, payload only
  always_ff @(posedge clk) begin
    if (win_we) begin
      rx_win_r[slot_r] <= rd_r;
      tx_win_r[slot_r] <= td_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      prev_rx_r <= '0;
      prev_tx_r <= '0;
      vld_r     <= '0;
      slot_r    <= '0;
      out_valid <= 1'b0;
      dir_r     <= 1'b0;
    end else begin
      // the finish step reloads the output register itself
      if (out_valid && !out_stall && (state_r != ST_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            rx_in_r  <= in_rx_total;
            tx_in_r  <= in_tx_total;
            primed_r <= ~in_clear_history && (prev_rx_r != '0);
            if (in_clear_history) begin
              prev_rx_r <= '0;
              prev_tx_r <= '0;
              vld_r     <= '0;
            end
            slot_r  <= (slot_r >= tppm_pkg::SLOT_END) ? '0 : slot_r + 1'b1;
            dir_r   <= 1'b0;
            state_r <= ST_DELTA;
          end
        end
        ST_DELTA: begin
          if (!dir_r) begin
            rd_r  <= primed_r ? cu_rsp.diff[tppm_pkg::CNT_W-1:0] : '0;
            dir_r <= 1'b1;
          end else begin
            td_r          <= td_nxt;
            vld_r[slot_r] <= 1'b1;
            prev_rx_r     <= rx_in_r;
            prev_tx_r     <= tx_in_r;
            rx_pk_r       <= '0;
            tx_pk_r       <= '0;
            idx_r         <= '0;
            dir_r         <= 1'b0;
            state_r       <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // replace the peak when the candidate is larger
          if (!cu_rsp.ge) begin
            if (dir_r) tx_pk_r <= cand;
            else       rx_pk_r <= cand;
          end
          if (!dir_r) begin
            dir_r <= 1'b1;
          end else begin
            dir_r <= 1'b0;
            if (idx_r == tppm_pkg::SLOT_END) begin
              state_r <= ST_DIVINIT;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        ST_DIVINIT: begin
          rem_r    <= num_full[tppm_pkg::NUM_W-1:tppm_pkg::PCT_W];
          num_lo_r <= num_full[tppm_pkg::PCT_W-1:0];
          bit_r    <= tppm_pkg::QBIT_TOP;
          q_r      <= '0;
          state_r  <= ST_DIV;
        end
        ST_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (cu_rsp.ge) begin
            rem_r <= cu_rsp.diff[tppm_pkg::CNT_W-1:0];
          end else begin
            rem_r <= cu_req.a[tppm_pkg::CNT_W-1:0];
          end
          q_r <= q_nxt;
          if (bit_r == '0) begin
            if (!dir_r) begin
              rx_pct_r <= pct_nxt;
              dir_r    <= 1'b1;
              state_r  <= ST_DIVINIT;
            end else begin
              tx_pct_r <= pct_nxt;
              dir_r    <= 1'b0;
              state_r  <= ST_FINISH;
            end
          end else begin
            bit_r <= bit_r - 1'b1;
          end
        end
        ST_FINISH: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            out_primed     <= primed_r;
            out_rx_delta   <= rd_r;
            out_tx_delta   <= td_r;
            out_rx_peak    <= rx_pk_r;
            out_tx_peak    <= tx_pk_r;
            out_rx_percent <= rx_pct_r;
            out_tx_percent <= tx_pct_r;
            state_r        <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= tppm_pkg::SLOT_END)
    else $error("window slot out of range");

  a_peak_covers_delta: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rx_peak >= out_rx_delta) && (out_tx_peak >= out_tx_delta))
    else $error("peak below its own delta");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rx_percent <= tppm_pkg::PCT_MAX) &&
                  (out_tx_percent <= tppm_pkg::PCT_MAX))
    else $error("percent above full scale");

  a_unprimed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_primed) |-> (out_rx_delta == '0) && (out_tx_delta == '0))
    else $error("unprimed item carries a delta");

  a_load_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && (!out_valid || !out_stall)) |=>
      (out_valid && state_r == ST_IDLE))
    else $error("result not loaded at end of item");

endmodule

`default_nettype wire
